// ===== hw/rtl/piecewise_linear_color_ramp_defines.svh =====
// assertion macros used by the top level of the colour ramp rtl
`ifndef PIECEWISE_LINEAR_COLOR_RAMP_DEFINES_SVH
`define PIECEWISE_LINEAR_COLOR_RAMP_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent and consequent in the same cycle
`define PLCR_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("plcr: same-cycle check failed");
// consequent in the cycle after the antecedent
`define PLCR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("plcr: next-cycle check failed");
`else
`define PLCR_ASSERT_SAME(label, clk, rst, ante, cons)
`define PLCR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== hw/rtl/plcr_pkg.sv =====
// shared constants, types and controller codes of the colour ramp
`timescale 1ns / 1ps
`default_nettype none

package plcr_pkg;

  localparam int MAX_POINTS  = 16;
  localparam int MIN_POINTS  = 2;
  localparam int SLOT_W      = $clog2(MAX_POINTS);
  localparam int POS_W       = 8;
  localparam int CHAN_W      = 8;
  localparam int NUM_LANES   = 3;
  localparam int COLOR_W     = NUM_LANES * CHAN_W;
  localparam int ENTRY_W     = POS_W + COLOR_W;
  localparam int COUNT_W     = 5;
  localparam int CNT_CMP_W   = (COUNT_W > SLOT_W + 1) ? COUNT_W : SLOT_W + 1;
  localparam int PROD_W      = (POS_W + 1) + (CHAN_W + 1);
  localparam int PROD_MAG_W  = POS_W + CHAN_W;
  localparam int DIV_STEPS   = PROD_MAG_W;
  localparam int STEP_W      = $clog2(DIV_STEPS);

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_MAP   = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_BASE_RD,
    S_BASE_CAP,
    S_MUL,
    S_DIV,
    S_FIX,
    S_OUT
  } state_t;

  typedef struct packed {
    logic store_point;
    logic start_map;
    logic rd_next;
    logic rd_base;
    logic seg_inc;
    logic take_end;
    logic take_base;
    logic mul;
    logic div_step;
    logic fix;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic advance;
  } sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/plcr_ctrl.sv =====
// sequencer of the colour ramp: search, multiply, divide, output
`timescale 1ns / 1ps
`default_nettype none

module plcr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          kind,
  output logic          out_valid,
  input  logic          out_ready,
  input  plcr_pkg::sts_t sts,
  output plcr_pkg::cmd_t cmd
);
  import plcr_pkg::*;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] cnt;
  logic [STEP_W-1:0] cnt_next;
  logic              out_free;
  logic              out_valid_next;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  assign cnt_next       = (state == S_DIV) ? cnt + 1'b1 : '0;
  assign out_valid_next = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && kind == KIND_MAP) state_next = S_SRCH_RD;
      end
      S_SRCH_RD:  state_next = S_SRCH_CMP;
      S_SRCH_CMP: state_next = sts.advance ? S_SRCH_RD : S_BASE_RD;
      S_BASE_RD:  state_next = S_BASE_CAP;
      S_BASE_CAP: state_next = S_MUL;
      S_MUL:      state_next = S_DIV;
      S_DIV: begin
        if (cnt == LAST_STEP) state_next = S_FIX;
      end
      S_FIX:      state_next = S_OUT;
      S_OUT: begin
        if (out_free) state_next = S_IDLE;
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready        = 1'b1;
        cmd.store_point = in_valid && kind == KIND_WRITE;
        cmd.start_map   = in_valid && kind == KIND_MAP;
      end
      S_SRCH_RD:  cmd.rd_next = 1'b1;
      S_SRCH_CMP: begin
        cmd.seg_inc  = sts.advance;
        cmd.take_end = !sts.advance;
      end
      S_BASE_RD:  cmd.rd_base   = 1'b1;
      S_BASE_CAP: cmd.take_base = 1'b1;
      S_MUL:      cmd.mul       = 1'b1;
      S_DIV:      cmd.div_step  = 1'b1;
      S_FIX:      cmd.fix       = 1'b1;
      S_OUT:      cmd.out_load  = out_free;
      default:    cmd           = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/plcr_dp.sv =====
// datapath of the colour ramp: point table, segment search, three divider lanes
`timescale 1ns / 1ps
`default_nettype none

module plcr_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  plcr_pkg::cmd_t                   cmd,
  output plcr_pkg::sts_t                   sts,
  input  logic                             cfg_we,
  input  logic [plcr_pkg::COUNT_W-1:0]     cfg_data,
  input  logic [plcr_pkg::SLOT_W-1:0]      point_slot,
  input  logic [plcr_pkg::POS_W-1:0]       point_position,
  input  logic [plcr_pkg::CHAN_W-1:0]      point_red,
  input  logic [plcr_pkg::CHAN_W-1:0]      point_green,
  input  logic [plcr_pkg::CHAN_W-1:0]      point_blue,
  input  logic [plcr_pkg::POS_W-1:0]       value,
  output logic [plcr_pkg::CHAN_W-1:0]      red,
  output logic [plcr_pkg::CHAN_W-1:0]      green,
  output logic [plcr_pkg::CHAN_W-1:0]      blue
);
  import plcr_pkg::*;

  logic [COUNT_W-1:0]          point_count;
  logic [ENTRY_W-1:0]          mem [MAX_POINTS];
  logic [ENTRY_W-1:0]          rd_data;
  logic [SLOT_W-1:0]           rd_addr;
  logic [POS_W-1:0]            value_r;
  logic [SLOT_W-1:0]           seg;
  logic [POS_W-1:0]            t0;
  logic [POS_W-1:0]            t1;
  logic [COLOR_W-1:0]          c0;
  logic [COLOR_W-1:0]          c1;
  logic [POS_W-1:0]            den_mag;
  logic                        den_zero;
  logic signed [POS_W:0]       num;
  logic signed [POS_W:0]       den;
  logic [POS_W:0]              den_abs;
  logic [CNT_CMP_W-1:0]        pc_ext;
  logic [CNT_CMP_W-1:0]        n_eff;
  logic [CNT_CMP_W-1:0]        seg_end;
  logic [NUM_LANES*CHAN_W-1:0] res_all;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= COUNT_W'(MIN_POINTS);
    end else if (cfg_we) begin
      point_count <= cfg_data;
    end
  end

  // point table
  assign rd_addr = cmd.rd_next ? seg + 1'b1 : seg;

  always_ff @(posedge clk) begin
    if (cmd.store_point) begin
      mem[point_slot] <= {point_position, point_red, point_green, point_blue};
    end
    if (cmd.rd_next || cmd.rd_base) begin
      rd_data <= mem[rd_addr];
    end
  end

  // segment search
  assign pc_ext  = CNT_CMP_W'(point_count);
  assign n_eff   = (pc_ext < CNT_CMP_W'(MIN_POINTS)) ? CNT_CMP_W'(MIN_POINTS) :
                   (pc_ext > CNT_CMP_W'(MAX_POINTS)) ? CNT_CMP_W'(MAX_POINTS) : pc_ext;
  assign seg_end = CNT_CMP_W'(seg) + CNT_CMP_W'(2);
  assign sts.advance = (seg_end < n_eff) && (rd_data[ENTRY_W-1 -: POS_W] < value_r);

  always_ff @(posedge clk) begin
    if (cmd.start_map) begin
      value_r <= value;
      seg     <= '0;
    end else if (cmd.seg_inc) begin
      seg     <= seg + 1'b1;
    end
    if (cmd.take_end) begin
      t1 <= rd_data[ENTRY_W-1 -: POS_W];
      c1 <= rd_data[COLOR_W-1:0];
    end
    if (cmd.take_base) begin
      t0 <= rd_data[ENTRY_W-1 -: POS_W];
      c0 <= rd_data[COLOR_W-1:0];
    end
  end

  assign num     = $signed({1'b0, value_r}) - $signed({1'b0, t0});
  assign den     = $signed({1'b0, t1}) - $signed({1'b0, t0});
  assign den_abs = den[POS_W] ? -den : den;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      den_mag  <= den_abs[POS_W-1:0];
      den_zero <= (t1 == t0);
    end
  end

  // one multiply and restoring divide lane per channel, red first
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    logic [CHAN_W-1:0]        base;
    logic [CHAN_W-1:0]        top;
    logic signed [CHAN_W:0]   diff;
    logic signed [PROD_W-1:0] prod;
    logic [PROD_W-1:0]        prod_abs;
    logic                     q_neg;
    logic [CHAN_W-1:0]        rem;
    logic [PROD_MAG_W-1:0]    quo;
    logic [CHAN_W:0]          sh;
    logic [CHAN_W:0]          sub;
    logic                     ge;
    logic signed [PROD_W-1:0] off;
    logic signed [PROD_W-1:0] sum;
    logic [CHAN_W-1:0]        res;

    assign base     = c0[COLOR_W-1-g*CHAN_W -: CHAN_W];
    assign top      = c1[COLOR_W-1-g*CHAN_W -: CHAN_W];
    assign diff     = $signed({1'b0, top}) - $signed({1'b0, base});
    assign prod     = PROD_W'(num) * PROD_W'(diff);
    assign prod_abs = prod[PROD_W-1] ? -prod : prod;

    assign sh  = {rem, quo[PROD_MAG_W-1]};
    assign sub = sh - {1'b0, den_mag};
    assign ge  = sh >= {1'b0, den_mag};

    assign off = den_zero ? '0 :
                 q_neg    ? -$signed({{(PROD_W-PROD_MAG_W){1'b0}}, quo}) :
                            $signed({{(PROD_W-PROD_MAG_W){1'b0}}, quo});
    assign sum = $signed({{(PROD_W-CHAN_W){1'b0}}, base}) + off;

    always_ff @(posedge clk) begin
      if (cmd.mul) begin
        quo   <= prod_abs[PROD_MAG_W-1:0];
        rem   <= '0;
        q_neg <= prod[PROD_W-1] ^ den[POS_W];
      end else if (cmd.div_step) begin
        if (ge) begin
          rem <= sub[CHAN_W-1:0];
          quo <= {quo[PROD_MAG_W-2:0], 1'b1};
        end else begin
          rem <= sh[CHAN_W-1:0];
          quo <= {quo[PROD_MAG_W-2:0], 1'b0};
        end
      end
      if (cmd.fix) begin
        if (sum[PROD_W-1]) begin
          res <= '0;
        end else if (sum > $signed(PROD_W'((1 << CHAN_W) - 1))) begin
          res <= '1;
        end else begin
          res <= sum[CHAN_W-1:0];
        end
      end
    end

    assign res_all[(NUM_LANES-1-g)*CHAN_W +: CHAN_W] = res;
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      red   <= res_all[3*CHAN_W-1 -: CHAN_W];
      green <= res_all[2*CHAN_W-1 -: CHAN_W];
      blue  <= res_all[CHAN_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/piecewise_linear_color_ramp.sv =====
// top level of the piecewise linear colour ramp
//
//   channel   direction  handshake             payload
//   in        input      in_valid / in_ready   kind, point_slot, point_position,
//                                              point_red, point_green, point_blue, value
//   out       output     out_valid / out_ready red, green, blue
//   config    input      cfg_we                cfg_data (point_count)
//
// a write beat is stored in the cycle it is taken; a map beat holds the block through the
//   search (0..14 segments skipped), base read, multiply, divide, fix and output states
// the search reads one table entry per compare; three divider lanes then run 16 steps
// one beat at a time; a finished colour waits in the output register while the next is taken
// rst is synchronous; the point table is not cleared, point_count returns to two
`timescale 1ns / 1ps
`default_nettype none
`include "piecewise_linear_color_ramp_defines.svh"

module piecewise_linear_color_ramp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         kind,
  input  logic [plcr_pkg::SLOT_W-1:0]  point_slot,
  input  logic [plcr_pkg::POS_W-1:0]   point_position,
  input  logic [plcr_pkg::CHAN_W-1:0]  point_red,
  input  logic [plcr_pkg::CHAN_W-1:0]  point_green,
  input  logic [plcr_pkg::CHAN_W-1:0]  point_blue,
  input  logic [plcr_pkg::POS_W-1:0]   value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [plcr_pkg::CHAN_W-1:0]  red,
  output logic [plcr_pkg::CHAN_W-1:0]  green,
  output logic [plcr_pkg::CHAN_W-1:0]  blue,
  input  logic                         cfg_we,
  input  logic [plcr_pkg::COUNT_W-1:0] cfg_data
);
  import plcr_pkg::*;

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: owns the handshakes and the divide step count
  plcr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: table, search compare, multiply, divide and saturate per channel
  plcr_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .point_slot     (point_slot),
    .point_position (point_position),
    .point_red      (point_red),
    .point_green    (point_green),
    .point_blue     (point_blue),
    .value          (value),
    .red            (red),
    .green          (green),
    .blue           (blue)
  );

  // a map beat keeps the block busy for at least the next cycle
  `PLCR_ASSERT_NEXT(a_busy_after_map, clk, rst, in_valid && in_ready && kind == KIND_MAP, !in_ready)
  // the output register is only reloaded once its colour has gone
  `PLCR_ASSERT_SAME(a_load_when_free, clk, rst, cmd.out_load, !out_valid || out_ready)
  // a reload always presents a result
  `PLCR_ASSERT_NEXT(a_load_sets_valid, clk, rst, cmd.out_load, out_valid)
  // table writes happen only on an accepted write beat
  `PLCR_ASSERT_SAME(a_store_on_beat, clk, rst, cmd.store_point, in_valid && in_ready && kind == KIND_WRITE)

endmodule

`default_nettype wire

// ===== dv/tb_piecewise_linear_color_ramp.sv =====
// self-checking testbench for the piecewise linear colour ramp
`timescale 1ns / 1ps

module tb_piecewise_linear_color_ramp;
  import plcr_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 10;
  // the longest lookup fits within this tail, so this covers a beat still in flight
  localparam int TAIL_CYCLES  = 64;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PHASE_BEATS  = 200;
  localparam int NUM_PHASES   = 9;

  // one input beat as the driver sees it
  typedef struct packed {
    logic                kind;
    logic [SLOT_W-1:0]   slot;
    logic [POS_W-1:0]    position;
    logic [CHAN_W-1:0]   r;
    logic [CHAN_W-1:0]   g;
    logic [CHAN_W-1:0]   b;
    logic [POS_W-1:0]    level;
  } ramp_beat_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } ramp_rgb_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                kind = KIND_WRITE;
  logic [SLOT_W-1:0]   point_slot = '0;
  logic [POS_W-1:0]    point_position = '0;
  logic [CHAN_W-1:0]   point_red = '0;
  logic [CHAN_W-1:0]   point_green = '0;
  logic [CHAN_W-1:0]   point_blue = '0;
  logic [POS_W-1:0]    value = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [CHAN_W-1:0]   red;
  logic [CHAN_W-1:0]   green;
  logic [CHAN_W-1:0]   blue;
  logic                cfg_we = 1'b0;
  logic [COUNT_W-1:0]  cfg_data = '0;

  piecewise_linear_color_ramp u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .point_slot     (point_slot),
    .point_position (point_position),
    .point_red      (point_red),
    .point_green    (point_green),
    .point_blue     (point_blue),
    .value          (value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .red            (red),
    .green          (green),
    .blue           (blue),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor state: our own copy of the point table and of point_count
  // ---------------------------------------------------------------------------
  logic [POS_W-1:0]   ramp_pos [MAX_POINTS];
  logic [COLOR_W-1:0] ramp_col [MAX_POINTS];
  logic [COUNT_W-1:0] ramp_count = 5'd2;

  ramp_rgb_t  expected_colours [$];
  ramp_beat_t pending_beats [$];

  // bookkeeping
  int beats_queued    = 0;
  int beats_taken     = 0;
  int points_stored   = 0;
  int lookups_taken   = 0;
  int colours_checked = 0;
  int mismatches      = 0;
  int settings_run    = 0;
  int cycle_count     = 0;
  logic in_taken      = 1'b0;

  // idle percentages for each side, switched between phases
  int send_idle_pct = 22;
  int recv_idle_pct = 50;

  // generator view of the table, so a lookup never touches an unwritten slot
  int               gen_written = 0;
  logic [POS_W-1:0] gen_pos [MAX_POINTS];

  // counts outside 2..MAX_POINTS are clamped by the block
  function automatic int points_in_use(input logic [COUNT_W-1:0] cnt);
    if (cnt < MIN_POINTS) return MIN_POINTS;
    if (cnt > MAX_POINTS) return MAX_POINTS;
    return int'(cnt);
  endfunction

  // c0 + num*(c1-c0)/den, truncated toward zero, then clipped to a byte
  function automatic logic [CHAN_W-1:0] lerp_channel(input logic [CHAN_W-1:0] c0,
                                                     input logic [CHAN_W-1:0] c1,
                                                     input int num, input int den);
    int base;
    int diff;
    int off;
    int sum;
    base = int'(c0);
    diff = int'(c1) - base;
    off  = 0;
    if (den != 0) off = (num * diff) / den;
    sum = base + off;
    if (sum < 0) return '0;
    if (sum > 255) return 8'd255;
    return sum[CHAN_W-1:0];
  endfunction

  // segment search then per-channel interpolation
  function automatic ramp_rgb_t ramp_lookup(input logic [POS_W-1:0] lvl);
    int n;
    int seg;
    int num;
    int den;
    logic [COLOR_W-1:0] lo_col;
    logic [COLOR_W-1:0] hi_col;
    ramp_rgb_t c;
    n   = points_in_use(ramp_count);
    seg = 0;
    // advance while the next point still lies below the value, never past n-2
    while (seg + 2 < n && ramp_pos[seg + 1] < lvl) seg++;
    num = int'(lvl) - int'(ramp_pos[seg]);
    den = int'(ramp_pos[seg + 1]) - int'(ramp_pos[seg]);
    lo_col  = ramp_col[seg];
    hi_col  = ramp_col[seg + 1];
    c.red   = lerp_channel(lo_col[23:16], hi_col[23:16], num, den);
    c.green = lerp_channel(lo_col[15:8], hi_col[15:8], num, den);
    c.blue  = lerp_channel(lo_col[7:0], hi_col[7:0], num, den);
    return c;
  endfunction

  task automatic check_channel(input string name, input logic [CHAN_W-1:0] want,
                               input logic [CHAN_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus builders
  // ---------------------------------------------------------------------------
  task automatic queue_beat(input ramp_beat_t bt);
    pending_beats.push_back(bt);
    beats_queued++;
  endtask

  // write beat; the value field is junk, the block must ignore it
  task automatic push_write(input int slot, input int pos, input int r, input int g, input int b);
    ramp_beat_t bt;
    bt.kind     = KIND_WRITE;
    bt.slot     = slot[SLOT_W-1:0];
    bt.position = pos[POS_W-1:0];
    bt.r        = r[CHAN_W-1:0];
    bt.g        = g[CHAN_W-1:0];
    bt.b        = b[CHAN_W-1:0];
    bt.level    = POS_W'($urandom_range(0, 255));
    gen_written = gen_written | (1 << slot);
    gen_pos[slot] = pos[POS_W-1:0];
    queue_beat(bt);
  endtask

  // lookup beat; point fields carry junk
  task automatic push_map(input int lvl);
    ramp_beat_t bt;
    bt.kind     = KIND_MAP;
    bt.slot     = SLOT_W'($urandom_range(0, MAX_POINTS - 1));
    bt.position = POS_W'($urandom_range(0, 255));
    bt.r        = CHAN_W'($urandom_range(0, 255));
    bt.g        = CHAN_W'($urandom_range(0, 255));
    bt.b        = CHAN_W'($urandom_range(0, 255));
    bt.level    = lvl[POS_W-1:0];
    queue_beat(bt);
  endtask

  // values near the points hit the strict "below" comparison of the search
  function automatic int pick_level(input int n);
    int sel;
    int lvl;
    sel = $urandom_range(0, 7);
    if (sel == 0) return 0;
    if (sel == 1) return 255;
    if (sel < 4) begin
      lvl = int'(gen_pos[$urandom_range(0, n - 1)]) + int'($urandom_range(0, 2)) - 1;
      if (lvl < 0) lvl = 0;
      if (lvl > 255) lvl = 255;
      return lvl;
    end
    return $urandom_range(0, 255);
  endfunction

  // a proper ramp: slots 0..n-1 with non-decreasing positions, random colours
  task automatic queue_ramp_points(input int n);
    int p [MAX_POINTS];
    int lo;
    int hi;
    int i;
    int j;
    int tmp;
    lo = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 200) : 0;
    hi = ($urandom_range(0, 3) == 0) ? lo + 15 : 255;   // narrow band gives ties
    if (hi > 255) hi = 255;
    for (i = 0; i < n; i++) p[i] = $urandom_range(lo, hi);
    for (i = 1; i < n; i++) begin
      j = i;
      while (j > 0 && p[j - 1] > p[j]) begin
        tmp = p[j]; p[j] = p[j - 1]; p[j - 1] = tmp;
        j--;
      end
    end
    for (i = 0; i < n; i++)
      push_write(i, p[i], $urandom_range(0, 255), $urandom_range(0, 255),
                 $urandom_range(0, 255));
  endtask

  // mostly whole ramps followed by lookups, the rest stray writes and lookups
  task automatic queue_phase(input int target);
    int added;
    int n;
    int k;
    int need;
    added = 0;
    n     = points_in_use(ramp_count);
    need  = (1 << n) - 1;
    while (added < target) begin
      if ($urandom_range(0, 9) < 7 || (gen_written & need) != need) begin
        queue_ramp_points(n);
        k = $urandom_range(4, 12);
        repeat (k) push_map(pick_level(n));
        added += n + k;
      end else begin
        k = $urandom_range(1, 4);
        repeat (k) begin
          if ($urandom_range(0, 1) == 0)
            push_write($urandom_range(0, MAX_POINTS - 1), $urandom_range(0, 255),
                       $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255));
          else
            push_map(pick_level(n));
        end
        added += k;
      end
    end
  endtask

  // wait for every beat to be taken and every colour to come back,
  // then let a trailing write or lookup settle
  task automatic wait_drained();
    while (beats_taken != beats_queued || expected_colours.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_point_count(input int cnt);
    @(negedge clk);
    cfg_we     <= 1'b1;
    cfg_data   <= cnt[COUNT_W-1:0];
    ramp_count = cnt[COUNT_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  // ---------------------------------------------------------------------------
  // input driver: new beat only once the previous one has been taken
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_beats
    ramp_beat_t nxt;
    if (rst) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (!in_valid || in_taken) begin
        if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = pending_beats.pop_front();
          in_valid       <= 1'b1;
          kind           <= nxt.kind;
          point_slot     <= nxt.slot;
          point_position <= nxt.position;
          point_red      <= nxt.r;
          point_green    <= nxt.g;
          point_blue     <= nxt.b;
          value          <= nxt.level;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: results are checked before this edge's input beat is predicted,
  // so a colour that turns up before its lookup is flagged
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_beats
    ramp_rgb_t want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (expected_colours.size() == 0) begin
          $error("colour beat with no lookup pending: %0d %0d %0d", red, green, blue);
          mismatches++;
        end else begin
          want = expected_colours.pop_front();
          check_channel("red", want.red, red);
          check_channel("green", want.green, green);
          check_channel("blue", want.blue, blue);
          colours_checked++;
        end
      end
      if (in_valid && in_ready) begin
        beats_taken++;
        if (kind == KIND_WRITE) begin
          ramp_pos[point_slot] = point_position;
          ramp_col[point_slot] = {point_red, point_green, point_blue};
          points_stored++;
        end else begin
          expected_colours.push_back(ramp_lookup(value));
          lookups_taken++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still pending", cycle_count,
               beats_queued - beats_taken);
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence: reset, directed cases, then one random phase per planned point_count
  // ---------------------------------------------------------------------------
  initial begin : run_test
    int plan [NUM_PHASES];
    int ph;
    plan = '{16, 0, 31, 2, 17, 1, 0, 8, 16};
    plan[6] = $urandom_range(3, 15);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part runs on the reset count of two points
    push_write(0, 0, 0, 0, 0);
    push_write(1, 255, 255, 255, 255);
    push_map(0);
    push_map(255);
    push_map(128);
    // both points on the same position: colour of the first point
    push_write(0, 255, 10, 20, 30);
    push_map(100);
    push_map(255);
    // extrapolation on both sides, rising and falling channels saturate
    push_write(0, 100, 0, 255, 128);
    push_write(1, 200, 255, 0, 128);
    push_map(0);
    push_map(255);
    push_map(150);
    // falling slope, truncation of a negative quotient toward zero
    push_write(0, 50, 255, 200, 0);
    push_write(1, 60, 0, 100, 255);
    push_map(55);
    push_map(51);
    // slot beyond the count in use, must not disturb lookups
    push_write(15, 7, 255, 255, 255);
    push_map(60);
    wait_drained();

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph / 3)
        0: begin
          send_idle_pct = 22;
          recv_idle_pct = 50;
        end
        1: begin
          send_idle_pct = 50;
          recv_idle_pct = 22;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_point_count(plan[ph]);
      @(posedge clk);
      queue_phase(PHASE_BEATS);
      wait_drained();
    end

    $display("covered %0d point writes and %0d lookups over %0d point_count settings",
             points_stored, lookups_taken, settings_run + 1);
    $display("%0d colours checked, %0d mismatches", colours_checked, mismatches);
    if (mismatches == 0 && expected_colours.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
